// ----- design/rhsl_pkg.sv -----
// ----------------------------------------------------------------------------
// rhsl_pkg: shared constants and types for the RGB to HSL converter
// Widths, divider step record and the pipeline data word.
// ----------------------------------------------------------------------------
`default_nettype none
package rhsl_pkg;
  localparam int COMP_W = 8;
  localparam int FRAC_W = 16;
  localparam int SUM_W  = COMP_W + 1;
  // hue divisor 6*delta
  localparam int HDEN_W = COMP_W + 3;
  // hue divisor scaled by 2^COMP_W over the leading steps
  localparam int HREM_W = HDEN_W + COMP_W;
  // saturation divisor up to MAXV
  localparam int SDEN_W = COMP_W;
  // division cells: COMP_W leading steps, then FRAC_W quotient bits
  localparam int STEPS  = COMP_W + FRAC_W;
  localparam int SIDX_W = $clog2(STEPS);
  localparam logic [COMP_W-1:0] COMP_MAX = {COMP_W{1'b1}};

  // long division: quotient bits one per cell, remainder carried along
  typedef struct packed {
    logic              vld;
    logic [HREM_W-1:0] h_rem;
    logic [HREM_W-1:0] h_den;
    logic [FRAC_W-1:0] h_quo;
    logic [SDEN_W:0]   s_rem;
    logic [SDEN_W-1:0] s_den;
    logic [FRAC_W-1:0] s_quo;
    logic [COMP_W-1:0] s_num;   // delta, its dividend streamed one bit per cell
    logic [SUM_W-1:0]  sum;
    logic              h_zero;
    logic              s_zero;
  } rhsl_word_t;
endpackage
`default_nettype wire

// ----- design/rhsl_front.sv -----
// ----------------------------------------------------------------------------
// rhsl_front: max/min, sector numerator and divisor setup
// Registers one pixel per cycle, while en is high, into the first division cell.
// ----------------------------------------------------------------------------
`default_nettype none
module rhsl_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_vld,
  input  wire logic [rhsl_pkg::COMP_W-1:0] red,
  input  wire logic [rhsl_pkg::COMP_W-1:0] green,
  input  wire logic [rhsl_pkg::COMP_W-1:0] blue,
  output rhsl_pkg::rhsl_word_t            word_r
);
  logic [rhsl_pkg::COMP_W-1:0] hi, lo, dl;
  logic [rhsl_pkg::SUM_W-1:0]  sum;
  logic [rhsl_pkg::HDEN_W-1:0] num, den6;
  logic [rhsl_pkg::SUM_W-1:0]  sden;
  rhsl_pkg::rhsl_word_t        word_nxt;

  always_comb begin
    hi = (red > green) ? red : green;
    hi = (hi > blue) ? hi : blue;
    lo = (red < green) ? red : green;
    lo = (lo < blue) ? lo : blue;
    dl = hi - lo;
    sum = {1'b0, hi} + {1'b0, lo};
    den6 = rhsl_pkg::HDEN_W'(dl) * rhsl_pkg::HDEN_W'(6);
    num = '0;
    if (hi == red && hi != green) begin
      if (green >= blue) num = rhsl_pkg::HDEN_W'(green - blue);
      else num = den6 - rhsl_pkg::HDEN_W'(blue - green);
    end else if (hi == green && hi != blue) begin
      num = rhsl_pkg::HDEN_W'({dl, 1'b0}) + rhsl_pkg::HDEN_W'(blue)
            - rhsl_pkg::HDEN_W'(red);
    end else if (hi == blue && hi != red) begin
      num = rhsl_pkg::HDEN_W'({dl, 2'b0}) + rhsl_pkg::HDEN_W'(red)
            - rhsl_pkg::HDEN_W'(green);
    end
    if (sum < rhsl_pkg::SUM_W'(rhsl_pkg::COMP_MAX)) sden = sum;
    else sden = {rhsl_pkg::COMP_MAX, 1'b0} - sum;
    word_nxt.vld    = in_vld;
    // num*2^F over den: divisor scaled so the leading steps give zero bits
    word_nxt.h_rem  = rhsl_pkg::HREM_W'(num);
    word_nxt.h_den  = {den6, {rhsl_pkg::COMP_W{1'b0}}};
    word_nxt.h_quo  = '0;
    // delta*(2^F-1) = delta*2^F - delta, streamed bit by bit into the cells
    word_nxt.s_rem  = '0;
    word_nxt.s_den  = sden[rhsl_pkg::SDEN_W-1:0];
    word_nxt.s_quo  = '0;
    word_nxt.s_num  = dl;
    word_nxt.sum    = sum;
    word_nxt.h_zero = (dl == '0);
    word_nxt.s_zero = (sden == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.vld <= 1'b0;
    end else if (en) begin
      word_r <= word_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- design/rhsl_cell.sv -----
// ----------------------------------------------------------------------------
// rhsl_cell: one restoring division step for hue and saturation
// Hue: rem*2 vs den. Saturation: dividend bit stream of (delta*2^F - delta).
// ----------------------------------------------------------------------------
`default_nettype none
module rhsl_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic [rhsl_pkg::STEPS-1:0]    s_dvd,
  input  wire logic [rhsl_pkg::SIDX_W-1:0]   s_idx,
  input  wire rhsl_pkg::rhsl_word_t          word_i,
  output rhsl_pkg::rhsl_word_t               word_r
);
  rhsl_pkg::rhsl_word_t word_nxt;
  logic [rhsl_pkg::HREM_W:0] h2;
  logic [rhsl_pkg::SDEN_W+1:0] s2;

  always_comb begin
    word_nxt = word_i;
    h2 = {word_i.h_rem, 1'b0};
    if (h2 >= {1'b0, word_i.h_den}) begin
      h2 = h2 - {1'b0, word_i.h_den};
      word_nxt.h_quo = {word_i.h_quo[rhsl_pkg::FRAC_W-2:0], 1'b1};
    end else begin
      word_nxt.h_quo = {word_i.h_quo[rhsl_pkg::FRAC_W-2:0], 1'b0};
    end
    word_nxt.h_rem = h2[rhsl_pkg::HREM_W-1:0];
    s2 = {word_i.s_rem, s_dvd[s_idx]};
    if (s2 >= {2'b0, word_i.s_den}) begin
      s2 = s2 - {2'b0, word_i.s_den};
      word_nxt.s_quo = {word_i.s_quo[rhsl_pkg::FRAC_W-2:0], 1'b1};
    end else begin
      word_nxt.s_quo = {word_i.s_quo[rhsl_pkg::FRAC_W-2:0], 1'b0};
    end
    word_nxt.s_rem = s2[rhsl_pkg::SDEN_W:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.vld <= 1'b0;
    end else if (en) begin
      word_r <= word_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- design/rgb_to_hsl_converter_top.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_top: streaming RGB to HSL converter
// ----------------------------------------------------------------------------
// Accepts one pixel per clock unless stalled and returns hue, saturation and
// max+min through a setup stage, a chain of 24
// restoring-division cells (8 leading steps where only the remainders build
// up, the hue divisor being scaled by 2^8 for them, then 16 quotient-bit
// steps shared by hue and saturation), and an output register. The whole
// chain advances when the output register is free or being taken, so
// back-pressure stalls it.
`default_nettype none
module rgb_to_hsl_converter_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rhsl_pkg::COMP_W-1:0] in_red,
  input  wire logic [rhsl_pkg::COMP_W-1:0] in_green,
  input  wire logic [rhsl_pkg::COMP_W-1:0] in_blue,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rhsl_pkg::FRAC_W-1:0]      out_hue,
  output logic [rhsl_pkg::FRAC_W-1:0]      out_saturation,
  output logic [rhsl_pkg::SUM_W-1:0]       out_lightness_sum
);
  logic en;
  rhsl_pkg::rhsl_word_t w [rhsl_pkg::STEPS+1];

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  rhsl_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
    .red(in_red), .green(in_green), .blue(in_blue), .word_r(w[0])
  );

  for (genvar i = 0; i < rhsl_pkg::STEPS; i++) begin : g_cell
    logic [rhsl_pkg::STEPS-1:0] dvd;
    assign dvd = {w[i].s_num, {rhsl_pkg::FRAC_W{1'b0}}} - rhsl_pkg::STEPS'(w[i].s_num);
    rhsl_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .s_dvd(dvd),
      .s_idx(rhsl_pkg::SIDX_W'(rhsl_pkg::STEPS - 1 - i)), .word_i(w[i]),
      .word_r(w[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= w[rhsl_pkg::STEPS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hue           <= w[rhsl_pkg::STEPS].h_zero ? '0 : w[rhsl_pkg::STEPS].h_quo;
      out_saturation    <= w[rhsl_pkg::STEPS].s_zero ? '0 : w[rhsl_pkg::STEPS].s_quo;
      out_lightness_sum <= w[rhsl_pkg::STEPS].sum;
    end
  end
endmodule
`default_nettype wire

// ----- design/rhsl_checker.sv -----
// ----------------------------------------------------------------------------
// rhsl_checker: port-level checks for the RGB to HSL converter
// Output relations that hold for every request.
// ----------------------------------------------------------------------------
`default_nettype none
module rhsl_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [rhsl_pkg::FRAC_W-1:0] out_hue,
  input wire logic [rhsl_pkg::FRAC_W-1:0] out_saturation,
  input wire logic [rhsl_pkg::SUM_W-1:0]  out_lightness_sum
);
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready) else $error("ready while stalled");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hue)))
    else $error("result dropped");
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_lightness_sum == '0) |-> (out_saturation == '0 && out_hue == '0))
    else $error("black pixel not zero");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lightness_sum <= {rhsl_pkg::COMP_MAX, 1'b0})
    else $error("sum out of range");
endmodule

bind rgb_to_hsl_converter_top rhsl_checker u_rhsl_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_hue(out_hue), .out_saturation(out_saturation),
  .out_lightness_sum(out_lightness_sum)
);
`default_nettype wire
